>>> src/avr_exec_pkg.sv
// Package for the AVR execute block: operation codes, flag positions,
// memory request types and parameter defaults. No dependencies.
`default_nettype none

package avr_exec_pkg;

  localparam int STACK_BYTES_DEF = 2048;
  localparam int PC_BITS_DEF     = 16;
  localparam int STK_ADDR_MAX    = 16;

  // Decoded operation codes
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_ADC   = 4'd1,
    OP_ADIW  = 4'd2,
    OP_BREAK = 4'd3,
    OP_BREQ  = 4'd4,
    OP_BRNE  = 4'd5,
    OP_CALL  = 4'd6,
    OP_CPI   = 4'd7,
    OP_LDI   = 4'd8,
    OP_MOV   = 4'd9,
    OP_NOP   = 4'd10,
    OP_POP   = 4'd11,
    OP_PUSH  = 4'd12,
    OP_RET   = 4'd13,
    OP_RJMP  = 4'd14
  } op_t;

  // Status register bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  localparam logic [7:0] ARITH_FLAGS = 8'h3F;
  localparam logic [7:0] ADIW_FLAGS  = 8'h1F;

  // Register file write port
  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [7:0] data;
  } rf_wr_t;

  // Stack memory request: one write and one read port
  typedef struct packed {
    logic                    wen;
    logic [STK_ADDR_MAX-1:0] waddr;
    logic [7:0]              wdata;
    logic                    ren;
    logic [STK_ADDR_MAX-1:0] raddr;
  } stk_req_t;

endpackage

`default_nettype wire

>>> src/avr_rf.sv
// 32 x 8 register file, two registered read ports, one write port.
// Valid bits give the all-zero reset. Uses avr_exec_pkg.
`default_nettype none

module avr_rf
  import avr_exec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rf_wr_t     wr,
  input  wire logic       rd_en,
  input  wire logic [4:0] addr_a,
  input  wire logic [4:0] addr_b,
  output logic      [7:0] data_a,
  output logic      [7:0] data_b
);

  logic [7:0]  mem [32];
  logic [31:0] vld;

  // Valid bits: cleared by reset, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered reads, with the same-cycle write forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == addr_a) data_a <= wr.data;
      else if (vld[addr_a])           data_a <= mem[addr_a];
      else                            data_a <= '0;
      if (wr.en && wr.addr == addr_b) data_b <= wr.data;
      else if (vld[addr_b])           data_b <= mem[addr_b];
      else                            data_b <= '0;
    end
  end

endmodule

`default_nettype wire

>>> src/avr_stk.sv
// Byte-wide stack memory with one write and one registered read port.
// Uses avr_exec_pkg for the request type.
`default_nettype none

module avr_stk
  import avr_exec_pkg::*;
#(
  parameter int DEPTH = STACK_BYTES_DEF,
  parameter int AW    = $clog2(STACK_BYTES_DEF)
) (
  input  wire logic     clk,
  input  wire stk_req_t req,
  output logic    [7:0] rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // Read, forwarding a write to the same byte
  always_ff @(posedge clk) begin
    if (req.ren) begin
      if (req.wen && req.waddr == req.raddr) rdata <= req.wdata;
      else                                   rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> src/avr_instruction_execute.sv
// AVR execute block: executes one decoded instruction per input item.
// Holds the register file (avr_rf) and stack memory (avr_stk) below it.
// Uses avr_exec_pkg.
//
// Input channel: in_valid/in_stall carry one decoded instruction per item.
// Output channel: out_valid/out_stall carry one result item per input item:
// next_pc, stack_ptr, status_flags, dest_value and halted.
// An accepted item reads its operands from the register file and stack
// memory at the accept edge; the result register is loaded from them when
// the item's last step finishes. ADIW, CALL and RET take an extra step,
// S_EXEC1 (a second register write, a second stack byte), unless halted.
// A new item is taken in the cycle its predecessor finishes; the extra
// step comes from the single write port of each memory and the single
// read port of the stack. Same-cycle read/write hits are forwarded.
// Reset clears the registers (via valid bits), status, PC and halt bit
// and sets the stack pointer to the top byte; stack bytes stay undefined.
// While out_stall holds a waiting result, the next item waits in its last
// step and in_stall stays high. After BREAK every item reports the state.
`default_nettype none

module avr_instruction_execute
  import avr_exec_pkg::*;
#(
  parameter int STACK_BYTES = STACK_BYTES_DEF,
  parameter int PC_BITS     = PC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [3:0]  operation,
  input  wire logic        [4:0]  dest_reg,
  input  wire logic        [4:0]  src_reg,
  input  wire logic        [7:0]  immediate,
  input  wire logic signed [11:0] branch_offset,
  input  wire logic        [15:0] call_target,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [15:0] next_pc,
  output logic             [10:0] stack_ptr,
  output logic             [7:0]  status_flags,
  output logic             [7:0]  dest_value,
  output logic                    halted
);

  localparam int SP_BITS = $clog2(STACK_BYTES);
  localparam logic [SP_BITS-1:0] SP_TOP = SP_BITS'(STACK_BYTES - 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC0, S_EXEC1} state_t;

  state_t state, state_next;

  // Architectural state
  logic [PC_BITS-1:0] pc, pc_next;
  logic [SP_BITS-1:0] sp, sp_next;
  logic [7:0]         sr, sr_next;
  logic               halt, halt_next;

  // Latched item
  logic [3:0]        op_q;
  logic [4:0]        d_q, rep_q, dh_q;
  logic [7:0]        imm_q;
  logic signed [11:0] off_q;
  logic [15:0]       tgt_q;
  logic [7:0]        hi_q;

  logic [7:0] rd_a, rd_b, stk_rdata, dest_next;
  rf_wr_t     rf_wr;
  stk_req_t   stk_req;

  logic acc, multi, last, done, out_free, fire0, fire1;
  logic [4:0] addr_a, addr_b;

  function automatic logic [SP_BITS-1:0] sp_pop(input logic [SP_BITS-1:0] v);
    return (v < SP_TOP) ? v + 1'b1 : SP_TOP;
  endfunction

  function automatic logic [SP_BITS-1:0] sp_dec(input logic [SP_BITS-1:0] v);
    return (v == '0) ? SP_TOP : v - 1'b1;
  endfunction

  function automatic logic [7:0] mk_flags(input logic c, input logic z, input logic n,
                                          input logic v, input logic h);
    logic [7:0] f;
    f = '0;
    f[FLAG_C] = c;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_V] = v;
    f[FLAG_S] = n ^ v;
    f[FLAG_H] = h;
    return f;
  endfunction

  // Handshake and step control
  assign out_free = !out_valid || !out_stall;
  assign multi    = !halt && (op_q == OP_ADIW || op_q == OP_CALL || op_q == OP_RET);
  assign last     = (state == S_EXEC1) || (state == S_EXEC0 && !multi);
  assign done     = last && out_free;
  assign fire0    = (state == S_EXEC0) && (multi || out_free);
  assign fire1    = (state == S_EXEC1) && out_free;
  assign in_stall = !((state == S_IDLE) || done);
  assign acc      = in_valid && !in_stall;

  // Operand read addresses at accept
  assign addr_a = (operation == OP_LDI) ? dest_reg + 5'd16 : dest_reg;
  assign addr_b = (operation == OP_ADIW) ? dest_reg + 5'd1 : src_reg;

  // Execute datapath
  logic [8:0]  sum9;
  logic [7:0]  ares, cres;
  logic [15:0] wres;
  logic [31:0] ret_w;
  logic        cin;
  logic        ah, ac, av, ch, cc, cv, wc, wv;

  always_comb begin
    cin  = (op_q == OP_ADC) ? sr[FLAG_C] : 1'b0;
    sum9 = {1'b0, rd_a} + {1'b0, rd_b} + {8'd0, cin};
    ares = sum9[7:0];
    ah = (rd_a[3] & rd_b[3]) | (rd_b[3] & ~ares[3]) | (~ares[3] & rd_a[3]);
    ac = (rd_a[7] & rd_b[7]) | (rd_b[7] & ~ares[7]) | (~ares[7] & rd_a[7]);
    av = (rd_a[7] & rd_b[7] & ~ares[7]) | (~rd_a[7] & ~rd_b[7] & ares[7]);
    cres = rd_a - imm_q;
    ch = (~rd_a[3] & imm_q[3]) | (imm_q[3] & cres[3]) | (cres[3] & ~rd_a[3]);
    cc = (~rd_a[7] & imm_q[7]) | (imm_q[7] & cres[7]) | (cres[7] & ~rd_a[7]);
    cv = (rd_a[7] & ~imm_q[7] & ~cres[7]) | (~rd_a[7] & imm_q[7] & cres[7]);
    wres = {rd_b, rd_a} + {8'd0, imm_q};
    wc = ~wres[15] & rd_b[7];
    wv = ~rd_b[7] & wres[15];
    ret_w = 32'(pc + PC_BITS'(2));
  end

  always_comb begin
    pc_next   = pc;
    sp_next   = sp;
    sr_next   = sr;
    halt_next = halt;
    dest_next = rd_a;
    rf_wr     = '0;
    stk_req   = '0;
    if (fire0 && !halt) begin
      case (op_q)
        OP_ADD, OP_ADC: begin
          sr_next = (sr & ~ARITH_FLAGS) |
                    (mk_flags(ac, ares == 8'd0, ares[7], av, ah) & ARITH_FLAGS);
          rf_wr     = '{en: 1'b1, addr: d_q, data: ares};
          dest_next = ares;
          pc_next   = pc + PC_BITS'(1);
        end
        OP_ADIW: begin
          rf_wr = '{en: 1'b1, addr: d_q, data: wres[7:0]};
        end
        OP_BREAK: halt_next = 1'b1;
        OP_BREQ: pc_next = sr[FLAG_Z] ? pc + PC_BITS'(off_q) + PC_BITS'(1)
                                      : pc + PC_BITS'(1);
        OP_BRNE: pc_next = sr[FLAG_Z] ? pc + PC_BITS'(1)
                                      : pc + PC_BITS'(off_q) + PC_BITS'(1);
        OP_CALL: begin
          stk_req.wen   = 1'b1;
          stk_req.waddr = STK_ADDR_MAX'(sp);
          stk_req.wdata = ret_w[7:0];
          sp_next       = sp_dec(sp);
        end
        OP_CPI: begin
          sr_next = (sr & ~ARITH_FLAGS) |
                    (mk_flags(cc, cres == 8'd0, cres[7], cv, ch) & ARITH_FLAGS);
          pc_next = pc + PC_BITS'(1);
        end
        OP_LDI: begin
          rf_wr     = '{en: 1'b1, addr: rep_q, data: imm_q};
          dest_next = imm_q;
          pc_next   = pc + PC_BITS'(1);
        end
        OP_MOV: begin
          rf_wr     = '{en: 1'b1, addr: d_q, data: rd_b};
          dest_next = rd_b;
          pc_next   = pc + PC_BITS'(1);
        end
        OP_POP: begin
          rf_wr     = '{en: 1'b1, addr: d_q, data: stk_rdata};
          dest_next = stk_rdata;
          sp_next   = sp_pop(sp);
          pc_next   = pc + PC_BITS'(1);
        end
        OP_PUSH: begin
          stk_req.wen   = 1'b1;
          stk_req.waddr = STK_ADDR_MAX'(sp);
          stk_req.wdata = rd_b;
          sp_next       = sp_dec(sp);
          pc_next       = pc + PC_BITS'(1);
        end
        OP_RET: sp_next = sp_pop(sp);
        OP_RJMP: pc_next = pc + PC_BITS'(off_q) + PC_BITS'(1);
        default: pc_next = pc + PC_BITS'(1);
      endcase
    end
    if (fire1) begin
      case (op_q)
        OP_ADIW: begin
          rf_wr   = '{en: 1'b1, addr: dh_q, data: wres[15:8]};
          sr_next = (sr & ~ADIW_FLAGS) |
                    (mk_flags(wc, wres == 16'd0, wres[15], wv, 1'b0) & ADIW_FLAGS);
          dest_next = wres[7:0];
          pc_next   = pc + PC_BITS'(1);
        end
        OP_CALL: begin
          stk_req.wen   = 1'b1;
          stk_req.waddr = STK_ADDR_MAX'(sp);
          stk_req.wdata = ret_w[15:8];
          sp_next       = sp_dec(sp);
          pc_next       = PC_BITS'(tgt_q);
        end
        OP_RET: begin
          sp_next = sp_pop(sp);
          pc_next = PC_BITS'({hi_q, stk_rdata});
        end
        default: pc_next = pc;
      endcase
    end
    // Stack reads: first pop byte at accept, second during RET
    stk_req.ren = (acc && !halt_next &&
                   (operation == OP_POP || operation == OP_RET)) ||
                  (fire0 && !halt && op_q == OP_RET);
    stk_req.raddr = STK_ADDR_MAX'(sp_pop(sp_next));
  end

  // Sequencer
  always_comb begin
    state_next = state;
    if (acc)                       state_next = S_EXEC0;
    else if (done)                 state_next = S_IDLE;
    else if (fire0 && multi)       state_next = S_EXEC1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      sp    <= SP_TOP;
      sr    <= '0;
      halt  <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      sp    <= sp_next;
      sr    <= sr_next;
      halt  <= halt_next;
    end
  end

  // Item fields, latched at accept, and the first RET stack byte
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q  <= operation;
      d_q   <= dest_reg;
      rep_q <= addr_a;
      dh_q  <= dest_reg + 5'd1;
      imm_q <= immediate;
      off_q <= branch_offset;
      tgt_q <= call_target;
    end
    if (fire0 && op_q == OP_RET) begin
      hi_q <= stk_rdata;
    end
  end

  // Result register
  logic [31:0] pc_wide, sp_wide;
  assign pc_wide = 32'(pc_next);
  assign sp_wide = 32'(sp_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      next_pc      <= pc_wide[15:0];
      stack_ptr    <= sp_wide[10:0];
      status_flags <= sr_next;
      dest_value   <= dest_next;
      halted       <= halt_next;
    end
  end

  avr_rf u_rf (
    .clk    (clk),
    .rst    (rst),
    .wr     (rf_wr),
    .rd_en  (acc),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rd_a),
    .data_b (rd_b)
  );

  avr_stk #(
    .DEPTH (STACK_BYTES),
    .AW    (SP_BITS)
  ) u_stk (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rf_wr.en && !stk_req.wen))
    else $error("memory write while idle");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt)
    else $error("halt bit cleared");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_TOP)
    else $error("stack pointer out of range");

  a_result_on_done: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("finished item gave no result");
`endif

endmodule

`default_nettype wire
